@@ hw/rtl/cimgv_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and the crc byte update for the configuration image validator
// no dependencies

package cimgv_pkg;

   // image layout
   localparam int HDR_BYTES = 16;

   // crc-32, reflected form
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   // register reset values
   localparam logic [31:0] MAGIC_RESET   = 32'h4150_5253;
   localparam logic [31:0] VERSION_RESET = 32'd2;
   localparam int          SIZE_RESET    = 1024;

   // header word positions
   localparam logic [1:0] SLOT_MAGIC   = 2'd0;
   localparam logic [1:0] SLOT_VERSION = 2'd1;
   localparam logic [1:0] SLOT_SIZE    = 2'd2;
   localparam logic [1:0] SLOT_CRC     = 2'd3;

   // result status codes; ST_OK also means no header error recorded
   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_TRUNCATED    = 3'd1,
      ST_BAD_MAGIC    = 3'd2,
      ST_BAD_VERSION  = 3'd3,
      ST_BAD_SIZE     = 3'd4,
      ST_CRC_MISMATCH = 3'd5
   } status_type;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      REG_MAGIC   = 2'd0,
      REG_VERSION = 2'd1,
      REG_SIZE    = 2'd2
   } reg_index_type;

   // fixed-width header compare values
   typedef struct packed {
      logic [31:0] magic;
      logic [31:0] version;
   } hdr_cfg_type;

   // one result transfer
   typedef struct packed {
      status_type  status;
      logic [31:0] crc;
   } result_type;

   // one byte of reflected crc-32, eight bit steps unrolled
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/cimgv_csr.sv @@
`timescale 1ns / 1ps
// apb-style register file: expected magic, expected version, payload size
// depends on cimgv_pkg

module cimgv_csr #(
   parameter int SIZE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [3:0]                   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready,
   output cimgv_pkg::hdr_cfg_type       hdr_cfg,
   output logic [SIZE_BITS-1:0]         cfg_size
);

   logic [31:0]          magic_ff;
   logic [31:0]          version_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic                 wr_en;
   logic [1:0]           reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[3:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= cimgv_pkg::MAGIC_RESET;
         version_ff <= cimgv_pkg::VERSION_RESET;
         size_ff    <= SIZE_BITS'(cimgv_pkg::SIZE_RESET);
      end else if (wr_en) begin
         unique case (reg_sel)
            cimgv_pkg::REG_MAGIC:   magic_ff   <= csr_pwdata;
            cimgv_pkg::REG_VERSION: version_ff <= csr_pwdata;
            cimgv_pkg::REG_SIZE:    size_ff    <= csr_pwdata[SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_sel)
         cimgv_pkg::REG_MAGIC:   csr_prdata = magic_ff;
         cimgv_pkg::REG_VERSION: csr_prdata = version_ff;
         cimgv_pkg::REG_SIZE:    csr_prdata = 32'(size_ff);
         default:                csr_prdata = 32'd0;
      endcase
   end

   assign hdr_cfg.magic   = magic_ff;
   assign hdr_cfg.version = version_ff;
   assign cfg_size        = size_ff;

endmodule

@@ hw/rtl/cimgv_core.sv @@
`timescale 1ns / 1ps
// byte stage, header check, crc update and result register
// depends on cimgv_pkg

module cimgv_core #(
   parameter int SIZE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cimgv_pkg::hdr_cfg_type       hdr_cfg,
   input  logic [SIZE_BITS-1:0]         cfg_size,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_data_byte,
   input  logic                         req_last_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output cimgv_pkg::result_type        rsp_result
);

   localparam int CNT_W = SIZE_BITS + 1;

   // input stage
   logic                    in_vld_ff;
   logic [7:0]              in_byte_ff;
   logic                    in_last_ff;

   // image state
   logic [CNT_W-1:0]        byte_count_ff, byte_count_in;
   logic [31:0]             word_shift_ff, word_shift_in;
   logic [31:0]             stored_crc_ff, stored_crc_in;
   logic [31:0]             crc_acc_ff, crc_acc_in;
   cimgv_pkg::status_type   first_error_ff, first_error_in;

   // result stage
   logic                    rsp_vld_ff;
   cimgv_pkg::result_type   rsp_res_ff, rsp_res_in;

   logic                    out_free;
   logic                    adv;
   logic                    in_hdr;
   logic                    pay_open;
   logic                    hdr_done_in;
   logic                    pay_open_in;
   logic [CNT_W-1:0]        pay_cnt;
   logic [CNT_W-1:0]        pay_cnt_in;
   logic [31:0]             size_word;

   // handshake: a byte moves on unless it is last and the result slot is taken
   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign adv       = in_vld_ff && (!in_last_ff || out_free);
   assign req_ready = !in_vld_ff || adv;

   assign size_word = 32'(cfg_size);
   assign in_hdr    = byte_count_ff < CNT_W'(cimgv_pkg::HDR_BYTES);
   assign pay_cnt   = byte_count_ff - CNT_W'(cimgv_pkg::HDR_BYTES);
   assign pay_open  = pay_cnt < CNT_W'(cfg_size);

   // next image state for the byte in the input stage
   always_comb begin
      byte_count_in  = byte_count_ff;
      word_shift_in  = word_shift_ff;
      stored_crc_in  = stored_crc_ff;
      crc_acc_in     = crc_acc_ff;
      first_error_in = first_error_ff;
      if (in_hdr) begin
         word_shift_in = {in_byte_ff, word_shift_ff[31:8]};
         if (byte_count_ff[1:0] == 2'b11) begin
            case (byte_count_ff[3:2])
               cimgv_pkg::SLOT_MAGIC: begin
                  if (word_shift_in != hdr_cfg.magic && first_error_ff == cimgv_pkg::ST_OK)
                     first_error_in = cimgv_pkg::ST_BAD_MAGIC;
               end
               cimgv_pkg::SLOT_VERSION: begin
                  if (word_shift_in != hdr_cfg.version && first_error_ff == cimgv_pkg::ST_OK)
                     first_error_in = cimgv_pkg::ST_BAD_VERSION;
               end
               cimgv_pkg::SLOT_SIZE: begin
                  if (word_shift_in != size_word && first_error_ff == cimgv_pkg::ST_OK)
                     first_error_in = cimgv_pkg::ST_BAD_SIZE;
               end
               default: stored_crc_in = word_shift_in;
            endcase
         end
         byte_count_in = byte_count_ff + CNT_W'(1);
      end else if (pay_open) begin
         crc_acc_in    = cimgv_pkg::crc32_byte(crc_acc_ff, in_byte_ff);
         byte_count_in = byte_count_ff + CNT_W'(1);
      end
   end

   // status from the updated state, first failing check wins
   assign hdr_done_in = byte_count_in >= CNT_W'(cimgv_pkg::HDR_BYTES);
   assign pay_cnt_in  = byte_count_in - CNT_W'(cimgv_pkg::HDR_BYTES);
   assign pay_open_in = pay_cnt_in < CNT_W'(cfg_size);

   always_comb begin
      rsp_res_in.crc = crc_acc_in ^ cimgv_pkg::CRC_INIT;
      if (!hdr_done_in)
         rsp_res_in.status = cimgv_pkg::ST_TRUNCATED;
      else if (first_error_in != cimgv_pkg::ST_OK)
         rsp_res_in.status = first_error_in;
      else if (pay_open_in)
         rsp_res_in.status = cimgv_pkg::ST_TRUNCATED;
      else if (rsp_res_in.crc != stored_crc_in)
         rsp_res_in.status = cimgv_pkg::ST_CRC_MISMATCH;
      else
         rsp_res_in.status = cimgv_pkg::ST_OK;
   end

   // input stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_vld_ff <= 1'b1;
      end else if (adv) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // image state, restarts after the last byte
   always_ff @(posedge clock) begin
      if (reset || (adv && in_last_ff)) begin
         byte_count_ff  <= '0;
         word_shift_ff  <= 32'd0;
         stored_crc_ff  <= 32'd0;
         crc_acc_ff     <= cimgv_pkg::CRC_INIT;
         first_error_ff <= cimgv_pkg::ST_OK;
      end else if (adv) begin
         byte_count_ff  <= byte_count_in;
         word_shift_ff  <= word_shift_in;
         stored_crc_ff  <= stored_crc_in;
         crc_acc_ff     <= crc_acc_in;
         first_error_ff <= first_error_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv && in_last_ff) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_last_ff) begin
         rsp_res_ff <= rsp_res_in;
      end
   end

   assign rsp_valid  = rsp_vld_ff;
   assign rsp_result = rsp_res_ff;

   // a new byte never lands on a stalled one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !adv) |-> !(req_valid && req_ready))
      else $error("input stage overwritten while stalled");

   // crc untouched while the header is still arriving
   a_crc_idle_in_header: assert property (@(posedge clock) disable iff (reset)
      in_hdr |-> (crc_acc_ff == cimgv_pkg::CRC_INIT))
      else $error("crc changed during header");

   // only header checks are recorded as first error
   a_first_error_code: assert property (@(posedge clock) disable iff (reset)
      (first_error_ff == cimgv_pkg::ST_OK) || (first_error_ff == cimgv_pkg::ST_BAD_MAGIC) ||
      (first_error_ff == cimgv_pkg::ST_BAD_VERSION) || (first_error_ff == cimgv_pkg::ST_BAD_SIZE))
      else $error("first error holds a non-header code");

   // the last byte restarts the image count
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      (adv && in_last_ff) |=> (byte_count_ff == '0) && rsp_vld_ff)
      else $error("image did not restart after last byte");

endmodule

@@ hw/rtl/config_image_validator.sv @@
`timescale 1ns / 1ps
// top level of the configuration image validator: csr block and checking core
// depends on cimgv_pkg, cimgv_csr, cimgv_core

// Accepts one image byte per clock cycle with no gaps needed between images;
// a last byte waits in the input stage while an earlier result is untaken. A
// byte is registered, then checked and folded into the crc as it leaves the
// input stage (one unrolled 8-bit crc-32 step is the longest path); a last
// byte loads the result, held on the rsp_ channel until taken. The first 16
// bytes are the header words (magic, version, size, crc, little-endian);
// exactly payload_size bytes after them feed the crc and later bytes up to the
// last are dropped. Register byte addresses: 0 magic, 4 version, 8 size.

module config_image_validator #(
   parameter int SIZE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_computed_crc
);

   cimgv_pkg::hdr_cfg_type  hdr_cfg;
   logic [SIZE_BITS-1:0]    cfg_size;
   cimgv_pkg::result_type   rsp_result;

   // register file
   cimgv_csr #(
      .SIZE_BITS (SIZE_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .hdr_cfg     (hdr_cfg),
      .cfg_size    (cfg_size)
   );

   // checking core
   cimgv_core #(
      .SIZE_BITS (SIZE_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .hdr_cfg       (hdr_cfg),
      .cfg_size      (cfg_size),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result    (rsp_result)
   );

   assign rsp_status       = rsp_result.status;
   assign rsp_computed_crc = rsp_result.crc;

endmodule
